FILE: sv/liu_pkg.sv
// Shared constants, control word types and tables for the linear interpolation upsampler.
`timescale 1ns / 1ps

package liu_pkg;

  // Sample and factor widths
  localparam int SAMPLE_W   = 8;
  localparam int FACTOR_W   = 5;
  localparam int MIN_FACTOR = 2;
  localparam int MAX_FACTOR = 16;
  localparam int J_W        = $clog2(MAX_FACTOR);

  // D * k stays below 2^12, so 2*D*k + N fits in 13 bits
  localparam int PROD_W     = SAMPLE_W + FACTOR_W;
  localparam int NUM_W      = PROD_W;

  // Exact division by 2N via ceil(2^18 / 2N): NUM_W bits times 2N stays below 2^18
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 17;
  localparam int MULT_W      = NUM_W + RECIP_W;

  // APB port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_FACTOR = 1'b0;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(MIN_FACTOR);

  // Microprogram steps
  typedef enum logic [2:0] {
    ST_WAIT,
    ST_ROUTE,
    ST_SPLIT,
    ST_MUL,
    ST_DIV,
    ST_POINT,
    ST_LAST,
    ST_MID
  } step_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_PASS,
    COND_HALF,
    COND_MORE
  } cond_t;

  // Source of an emitted point
  typedef enum logic [1:0] {
    SRC_MID,
    SRC_INTERP,
    SRC_CUR
  } src_t;

  typedef struct packed {
    logic  take_in;
    logic  emit;
    src_t  src;
    logic  emit_last;
    logic  ld_j;
    logic  do_mul;
    logic  do_div;
    logic  adv_j;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic pass;
    logic half;
    logic more;
  } seq_status_t;

  // Microcode store
  function automatic ctrl_word_t ucode(step_t s);
    ctrl_word_t w;
    w        = '0;
    w.src    = SRC_CUR;
    w.cond   = COND_NEVER;
    w.target = ST_WAIT;
    unique case (s)
      ST_WAIT:  w.take_in = 1'b1;
      ST_ROUTE: begin
        w.cond   = COND_PASS;
        w.target = ST_LAST;
      end
      ST_SPLIT: begin
        w.ld_j   = 1'b1;
        w.cond   = COND_HALF;
        w.target = ST_MID;
      end
      ST_MUL:   w.do_mul = 1'b1;
      ST_DIV:   w.do_div = 1'b1;
      ST_POINT: begin
        w.emit   = 1'b1;
        w.src    = SRC_INTERP;
        w.adv_j  = 1'b1;
        w.cond   = COND_MORE;
        w.target = ST_MUL;
      end
      ST_LAST:  begin
        w.emit      = 1'b1;
        w.src       = SRC_CUR;
        w.emit_last = 1'b1;
        w.cond      = COND_ALWAYS;
        w.target    = ST_WAIT;
      end
      ST_MID:   begin
        w.emit   = 1'b1;
        w.src    = SRC_MID;
        w.cond   = COND_ALWAYS;
        w.target = ST_LAST;
      end
      default:  w.take_in = 1'b1;
    endcase
    return w;
  endfunction

  // ceil(2^18 / (2N)) for each usable factor
  function automatic logic [RECIP_W-1:0] recip(logic [FACTOR_W-1:0] n);
    logic [RECIP_W-1:0] r;
    r = '0;
    unique case (n)
      5'd2:    r = 17'd65536;
      5'd3:    r = 17'd43691;
      5'd4:    r = 17'd32768;
      5'd5:    r = 17'd26215;
      5'd6:    r = 17'd21846;
      5'd7:    r = 17'd18725;
      5'd8:    r = 17'd16384;
      5'd9:    r = 17'd14564;
      5'd10:   r = 17'd13108;
      5'd11:   r = 17'd11916;
      5'd12:   r = 17'd10923;
      5'd13:   r = 17'd10083;
      5'd14:   r = 17'd9363;
      5'd15:   r = 17'd8739;
      5'd16:   r = 17'd8192;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/liu_sample_if.sv
// Input channel: one sample request with its record start flag.
`timescale 1ns / 1ps

interface liu_sample_if import liu_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       record_start;

  modport source (output valid, sample, record_start, input ready);
  modport sink   (input valid, sample, record_start, output ready);
endinterface

FILE: sv/liu_point_if.sv
// Output channel: one point request with its end-of-run flag.
`timescale 1ns / 1ps

interface liu_point_if import liu_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] point;
  logic                       last;

  modport source (output valid, point, last, input ready);
  modport sink   (input valid, point, last, output ready);
endinterface

FILE: sv/liu_sequencer.sv
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps

module liu_sequencer import liu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  seq_status_t status,
  output ctrl_word_t  ctrl,
  output logic        fire
);

  step_t upc, upc_next;
  logic  jump;

  // Control word of the current step; a step holds while its request cannot move
  always_comb begin
    ctrl = ucode(upc);
    fire = !((ctrl.take_in && !status.in_valid) || (ctrl.emit && !status.out_free));
  end

  // Next step
  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:  jump = 1'b0;
      COND_ALWAYS: jump = 1'b1;
      COND_PASS:   jump = status.pass;
      COND_HALF:   jump = status.half;
      COND_MORE:   jump = status.more;
      default:     jump = 1'b0;
    endcase
    if (!fire) begin
      upc_next = upc;
    end else if (jump) begin
      upc_next = ctrl.target;
    end else begin
      upc_next = step_t'(upc + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

FILE: sv/linear_interp_upsampler.sv
// Top level of the linear interpolation upsampler: APB register, datapath and output stage.
//
// Usage: samples (sample, record_start) come in on a valid/ready channel, points
// (point, last) leave on another. Each sample request yields a run of points ending
// with last = 1: a record start (or the first sample after reset) gives the sample
// alone; otherwise N-1 interpolated points then the sample itself, N being the
// upsample_factor register clamped to 2..16. The register sits at APB address 0, and the
// user must write it only while the block is idle; the block itself does not enforce this.
// Timing: a sample is taken in the wait step, so at most one request is in work.
// A pass-through sample runs the wait, route and last steps; N = 2 runs wait, route,
// split, mid and last; N > 2 runs wait, route and split, then for each interpolated
// point a multiply step, a reciprocal multiply step and an emit step, then last.
// After the route step, the first emit step puts the first point on the output.
// Reset returns the sequencer to its wait step, empties the output register, sets the
// factor to 2 and forgets the previous sample. A stalled receiver holds the output
// register; the sequencer waits at its next emit step, and the next sample can be
// taken while the final point of a run is still waiting.
`timescale 1ns / 1ps

module linear_interp_upsampler import liu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  liu_sample_if.sink            samples,
  liu_point_if.source           points,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  ctrl_word_t  ctrl;
  seq_status_t status;
  logic        fire;

  logic [FACTOR_W-1:0]        factor;
  logic [FACTOR_W-1:0]        nfac;
  logic signed [SAMPLE_W-1:0] cur_s;
  logic signed [SAMPLE_W-1:0] prev_s;
  logic                       pass;
  logic                       have_prev;
  logic [J_W-1:0]             j;
  logic [NUM_W-1:0]           num;
  logic [SAMPLE_W-1:0]        quo;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_point;
  logic                       out_last;

  logic                       rising;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W:0]   diff_neg;
  logic [SAMPLE_W-1:0]        absd;
  logic signed [SAMPLE_W-1:0] lower;
  logic [FACTOR_W-1:0]        kval;
  logic [PROD_W-1:0]          prod;
  logic [NUM_W-1:0]           num_next;
  logic [MULT_W-1:0]          wide;
  logic signed [SAMPLE_W:0]   sum;
  logic signed [SAMPLE_W:0]   sum_adj;
  logic signed [SAMPLE_W-1:0] mid;
  logic signed [SAMPLE_W-1:0] interp;
  logic signed [SAMPLE_W-1:0] emit_val;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FACTOR) ? APB_DATA_W'(factor) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= FACTOR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FACTOR) begin
      factor <= pwdata[FACTOR_W-1:0];
    end
  end

  // Effective factor, clamped to the supported range
  always_comb begin
    if (factor < FACTOR_W'(MIN_FACTOR)) begin
      nfac = FACTOR_W'(MIN_FACTOR);
    end else if (factor > FACTOR_W'(MAX_FACTOR)) begin
      nfac = FACTOR_W'(MAX_FACTOR);
    end else begin
      nfac = factor;
    end
  end

  // Sequencer
  assign status.in_valid = samples.valid;
  assign status.out_free = !out_valid || points.ready;
  assign status.pass     = pass;
  assign status.half     = (nfac == FACTOR_W'(MIN_FACTOR));
  assign status.more     = (FACTOR_W'(j) != nfac - FACTOR_W'(1));

  liu_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .fire   (fire)
  );

  assign samples.ready = ctrl.take_in;

  // Difference, direction and lower endpoint
  always_comb begin
    rising   = cur_s > prev_s;
    diff     = {cur_s[SAMPLE_W-1], cur_s} - {prev_s[SAMPLE_W-1], prev_s};
    diff_neg = -diff;
    absd     = rising ? diff[SAMPLE_W-1:0] : diff_neg[SAMPLE_W-1:0];
    lower    = rising ? prev_s : cur_s;
  end

  // Numerator 2*D*k + N, k counted from the lower endpoint
  always_comb begin
    kval     = rising ? FACTOR_W'(j) : nfac - FACTOR_W'(j);
    prod     = PROD_W'(absd) * PROD_W'(kval);
    num_next = NUM_W'({prod[PROD_W-2:0], 1'b0}) + NUM_W'(nfac);
  end

  // Quotient by 2N through the reciprocal table
  assign wide = MULT_W'(num) * MULT_W'(recip(nfac));

  // Midpoint for N = 2, truncated toward zero, and interpolated point from the lower endpoint
  always_comb begin
    sum     = {prev_s[SAMPLE_W-1], prev_s} + {cur_s[SAMPLE_W-1], cur_s};
    sum_adj = sum + (SAMPLE_W + 1)'(sum[SAMPLE_W]);
    mid     = sum_adj[SAMPLE_W:1];
    interp  = lower + $signed(quo);
  end

  // Point selection
  always_comb begin
    unique case (ctrl.src)
      SRC_MID:    emit_val = mid;
      SRC_INTERP: emit_val = interp;
      SRC_CUR:    emit_val = cur_s;
      default:    emit_val = cur_s;
    endcase
  end

  // Sample history and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_s     <= '0;
      have_prev <= 1'b0;
      pass      <= 1'b0;
    end else if (fire && ctrl.take_in) begin
      cur_s     <= samples.sample;
      have_prev <= 1'b1;
      pass      <= samples.record_start || !have_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctrl.take_in) begin
      prev_s <= cur_s;
    end
  end

  // Point counter and arithmetic registers
  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
    end else if (fire && ctrl.ld_j) begin
      j <= J_W'(1);
    end else if (fire && ctrl.adv_j) begin
      j <= j + J_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctrl.do_mul) begin
      num <= num_next;
    end
    if (fire && ctrl.do_div) begin
      quo <= wide[RECIP_SHIFT +: SAMPLE_W];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (points.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctrl.emit) begin
      out_point <= emit_val;
      out_last  <= ctrl.emit_last;
    end
  end

  assign points.valid = out_valid;
  assign points.point = out_point;
  assign points.last  = out_last;

endmodule

FILE: sv/liu_checker.sv
// Port-level assertions for the upsampler, bound to the top level.
`timescale 1ns / 1ps

module liu_checker import liu_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_point,
  input logic                       out_last
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A waiting point holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_point) && $stable(out_last))
    else $error("stalled point changed");

  // A new sample is only taken once the previous run has reached its final point
  a_run_done: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(out_valid && !out_last))
    else $error("sample taken during a run");

  // One sample at a time: ready drops right after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back sample acceptance");

endmodule

bind linear_interp_upsampler liu_checker u_liu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (points.valid),
  .out_ready (points.ready),
  .out_point (points.point),
  .out_last  (points.last)
);
